// ===== hdl/vrw_pkg.sv =====
// vrw_pkg: shared types and codes for the velocity ramp with watchdog
// no dependencies; used by every module of the block but the watchdog, by scoped names

package vrw_pkg;

  // command field encoding
  typedef enum logic {
    CMD_VELOCITY = 1'b0,
    CMD_TICK     = 1'b1
  } command_t;

  // configuration port geometry
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LINEAR_LIMIT  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGULAR_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_PER_TICK = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIMEOUT_TICKS = 2'd3;

  // register reset values
  localparam logic [14:0] LINEAR_LIMIT_RST  = 15'd4096;
  localparam logic [14:0] ANGULAR_LIMIT_RST = 15'd4096;
  localparam logic [14:0] STEP_PER_TICK_RST = 15'd16;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd250;

  // per-beat control to every lane
  typedef struct packed {
    logic load;   // velocity command beat accepted
    logic tick;   // control tick beat accepted
    logic fired;  // watchdog zeroes targets on this tick
  } lane_ctrl_t;

  // one result beat
  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] yaw;
    logic               timed_out;
  } result_t;

endpackage

// ===== hdl/vrw_lane.sv =====
// vrw_lane: one axis of the ramp, target clamp plus slew-limited current velocity
// depends on vrw_pkg (lane_ctrl_t)

module vrw_lane #(
  parameter int VEL_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  vrw_pkg::lane_ctrl_t         ctrl,
  input  logic signed [15:0]          cmd_value,
  input  logic [14:0]                 limit,
  input  logic [14:0]                 step,
  output logic signed [VEL_WIDTH-1:0] cur_next
);

  // clamp width holds the 16-bit command and the velocity range plus sign
  localparam int CW = ((VEL_WIDTH > 16) ? VEL_WIDTH : 16) + 1;
  // difference width holds tgt - cur and the 15-bit step
  localparam int DW = ((VEL_WIDTH + 1 > 16) ? VEL_WIDTH + 1 : 16) + 1;
  localparam logic signed [CW-1:0] VMAX =
    {{(CW-VEL_WIDTH+1){1'b0}}, {(VEL_WIDTH-1){1'b1}}};

  logic signed [VEL_WIDTH-1:0] cur;
  logic signed [VEL_WIDTH-1:0] tgt;
  logic signed [VEL_WIDTH-1:0] tgt_clamped;
  logic signed [VEL_WIDTH-1:0] tgt_eff;
  logic signed [CW-1:0]        lim_raw;
  logic signed [CW-1:0]        lim;
  logic signed [CW-1:0]        cmd_w;
  logic signed [CW-1:0]        clamped_w;
  logic signed [DW-1:0]        diff;
  logic signed [DW-1:0]        step_w;
  logic signed [DW-1:0]        ramp_w;

  // clamp the command to +-min(limit, largest velocity)
  always_comb begin
    lim_raw = {{(CW-15){1'b0}}, limit};
    lim     = (lim_raw > VMAX) ? VMAX : lim_raw;
    cmd_w   = CW'(cmd_value);
    if (cmd_w > lim) begin
      clamped_w = lim;
    end else if (cmd_w < -lim) begin
      clamped_w = -lim;
    end else begin
      clamped_w = cmd_w;
    end
    tgt_clamped = clamped_w[VEL_WIDTH-1:0];
  end

  // move toward the target by at most one step
  always_comb begin
    tgt_eff = ctrl.fired ? '0 : tgt;
    diff    = DW'(tgt_eff) - DW'(cur);
    step_w  = {{(DW-15){1'b0}}, step};
    if (diff > step_w) begin
      ramp_w = DW'(cur) + step_w;
    end else if (diff < -step_w) begin
      ramp_w = DW'(cur) - step_w;
    end else begin
      ramp_w = DW'(tgt_eff);
    end
    cur_next = ramp_w[VEL_WIDTH-1:0];
  end

  // lane state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      tgt <= '0;
    end else if (ctrl.load) begin
      tgt <= tgt_clamped;
    end else if (ctrl.tick) begin
      cur <= cur_next;
      tgt <= tgt_eff;
    end
  end

endmodule

// ===== hdl/vrw_watchdog.sv =====
// vrw_watchdog: saturating tick counter since the last command, timeout flag
// no package dependencies

module vrw_watchdog #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic        tick,
  input  logic [15:0] timeout_ticks,
  output logic        fired
);

  localparam int MW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] TOP = '1;

  logic [COUNT_WIDTH-1:0] count;
  logic [MW-1:0]          count_w;
  logic [MW-1:0]          limit_w;
  logic                   at_top;

  // fires when the count after this tick's increment exceeds the timeout;
  // a saturated count only fires when it is already past the timeout
  always_comb begin
    count_w = MW'(count);
    limit_w = MW'(timeout_ticks);
    at_top  = (count == TOP);
    fired   = (count_w >= limit_w) && !(at_top && (limit_w == MW'(TOP)));
  end

  // counter, cleared by a command, saturating on ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= '0;
    end else if (tick && !at_top) begin
      count <= count + COUNT_WIDTH'(1);
    end
  end

endmodule

// ===== hdl/vrw_merge.sv =====
// vrw_merge: combines lane velocities and the watchdog flag into one result beat,
// with an output register and a skid register; depends on vrw_pkg (result_t)

module vrw_merge #(
  parameter int VEL_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        produce,
  input  logic signed [VEL_WIDTH-1:0] vx,
  input  logic signed [VEL_WIDTH-1:0] vy,
  input  logic signed [VEL_WIDTH-1:0] yaw,
  input  logic                        fired,
  input  logic                        out_stall,
  output logic                        out_valid,
  output vrw_pkg::result_t            beat,
  output logic                        skid_valid
);

  localparam int EW = (VEL_WIDTH > 16) ? VEL_WIDTH : 16;

  logic signed [EW-1:0] vx_e;
  logic signed [EW-1:0] vy_e;
  logic signed [EW-1:0] yaw_e;
  vrw_pkg::result_t     merged;
  vrw_pkg::result_t     skid;

  // low 16 bits of each velocity, sign-extended when the lanes are narrower
  always_comb begin
    vx_e             = EW'(vx);
    vy_e             = EW'(vy);
    yaw_e            = EW'(yaw);
    merged.vx        = vx_e[15:0];
    merged.vy        = vy_e[15:0];
    merged.yaw       = yaw_e[15:0];
    merged.timed_out = fired;
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid  <= skid_valid || produce;
      skid_valid <= 1'b0;
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      beat <= skid_valid ? skid : merged;
    end else if (produce) begin
      skid <= merged;
    end
  end

endmodule

// ===== hdl/velocity_ramp_with_watchdog_unit.sv =====
// velocity_ramp_with_watchdog_unit: top level, config registers, three axis lanes,
// watchdog and result merge; depends on vrw_pkg, vrw_lane, vrw_watchdog, vrw_merge
// a tick beat's result is registered in the output register, or the skid on a stall
// throughput: one beat per cycle, commands and ticks alike, unless skid is full;
//   each lane's clamp or one-step ramp is combinational, the merge registers it
// reset: synchronous, clears velocities, targets, the watchdog count and loads
//   register defaults; no clearing pass, beats are taken from the first cycle after

module velocity_ramp_with_watchdog_unit #(
  parameter int VEL_WIDTH   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   command,
  input  logic signed [15:0]                     vx_cmd,
  input  logic signed [15:0]                     vy_cmd,
  input  logic signed [15:0]                     yaw_cmd,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [15:0]                     vx_out,
  output logic signed [15:0]                     vy_out,
  output logic signed [15:0]                     yaw_out,
  output logic                                   timed_out,
  input  logic                                   cfg_we,
  input  logic [vrw_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [vrw_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

  logic [14:0]                 linear_limit;
  logic [14:0]                 angular_limit;
  logic [14:0]                 step_per_tick;
  logic [15:0]                 timeout_ticks;
  logic                        accept;
  logic                        fired;
  logic                        skid_valid;
  vrw_pkg::lane_ctrl_t         ctrl;
  vrw_pkg::result_t            beat;
  logic signed [VEL_WIDTH-1:0] vx_next;
  logic signed [VEL_WIDTH-1:0] vy_next;
  logic signed [VEL_WIDTH-1:0] yaw_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      linear_limit  <= vrw_pkg::LINEAR_LIMIT_RST;
      angular_limit <= vrw_pkg::ANGULAR_LIMIT_RST;
      step_per_tick <= vrw_pkg::STEP_PER_TICK_RST;
      timeout_ticks <= vrw_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vrw_pkg::REG_LINEAR_LIMIT:  linear_limit  <= cfg_data[14:0];
        vrw_pkg::REG_ANGULAR_LIMIT: angular_limit <= cfg_data[14:0];
        vrw_pkg::REG_STEP_PER_TICK: step_per_tick <= cfg_data[14:0];
        vrw_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // input beat decode; only a full skid register holds off the input
  assign in_stall   = skid_valid;
  assign accept     = in_valid && !in_stall;
  assign ctrl.load  = accept && (command == vrw_pkg::CMD_VELOCITY);
  assign ctrl.tick  = accept && (command == vrw_pkg::CMD_TICK);
  assign ctrl.fired = fired;

  vrw_watchdog #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_watchdog (
    .clk          (clk),
    .rst          (rst),
    .load         (ctrl.load),
    .tick         (ctrl.tick),
    .timeout_ticks(timeout_ticks),
    .fired        (fired)
  );

  // one lane per axis
  vrw_lane #(
    .VEL_WIDTH(VEL_WIDTH)
  ) u_lane_x (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .cmd_value(vx_cmd),
    .limit    (linear_limit),
    .step     (step_per_tick),
    .cur_next (vx_next)
  );

  vrw_lane #(
    .VEL_WIDTH(VEL_WIDTH)
  ) u_lane_y (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .cmd_value(vy_cmd),
    .limit    (linear_limit),
    .step     (step_per_tick),
    .cur_next (vy_next)
  );

  vrw_lane #(
    .VEL_WIDTH(VEL_WIDTH)
  ) u_lane_yaw (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .cmd_value(yaw_cmd),
    .limit    (angular_limit),
    .step     (step_per_tick),
    .cur_next (yaw_next)
  );

  vrw_merge #(
    .VEL_WIDTH(VEL_WIDTH)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .produce   (ctrl.tick),
    .vx        (vx_next),
    .vy        (vy_next),
    .yaw       (yaw_next),
    .fired     (fired),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .beat      (beat),
    .skid_valid(skid_valid)
  );

  // result beat onto the ports
  assign vx_out    = beat.vx;
  assign vy_out    = beat.vy;
  assign yaw_out   = beat.yaw;
  assign timed_out = beat.timed_out;

endmodule

// ===== hdl/vrw_checker.sv =====
// vrw_checker: port-level assertions for velocity_ramp_with_watchdog_unit
// depends on vrw_pkg; bound to the top level at the end of this file

module vrw_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                command,
  input logic signed [15:0]                  vx_out,
  input logic signed [15:0]                  vy_out,
  input logic signed [15:0]                  yaw_out,
  input logic                                timed_out,
  input logic                                out_valid,
  input logic                                out_stall
);

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vx_out) && $stable(vy_out)
      && $stable(yaw_out) && $stable(timed_out))
    else $error("stalled result beat changed");

  // a command beat into an empty output makes no result
  a_cmd_silent: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_valid && !in_stall && (command == vrw_pkg::CMD_VELOCITY)
      |=> !out_valid)
    else $error("command beat produced a result");

  // a tick beat into an empty output shows its result next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_valid && !in_stall && (command == vrw_pkg::CMD_TICK)
      |=> out_valid)
    else $error("tick beat produced no result");

  // input holds off only while results are backed up
  a_stall_backed: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind velocity_ramp_with_watchdog_unit vrw_checker u_vrw_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .command  (command),
  .vx_out   (vx_out),
  .vy_out   (vy_out),
  .yaw_out  (yaw_out),
  .timed_out(timed_out),
  .out_valid(out_valid),
  .out_stall(out_stall)
);

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for velocity_ramp_with_watchdog_unit, predicts the ramped
// velocities and the watchdog flag of every tick beat; depends on vrw_pkg and the unit

// predicts tick results from accepted beats and checks the unit's result beats
class ramp_scoreboard;
  vrw_pkg::result_t awaited_ramp[$];
  logic [14:0] linear_cap;
  logic [14:0] angular_cap;
  logic [14:0] ramp_step;
  logic [15:0] watchdog_span;
  int speed[3];
  int goal[3];
  logic [15:0] quiet_ticks;
  int mismatches;

  function new();
    linear_cap    = vrw_pkg::LINEAR_LIMIT_RST;
    angular_cap   = vrw_pkg::ANGULAR_LIMIT_RST;
    ramp_step     = vrw_pkg::STEP_PER_TICK_RST;
    watchdog_span = vrw_pkg::TIMEOUT_TICKS_RST;
    foreach (speed[i]) begin
      speed[i] = 0;
      goal[i]  = 0;
    end
    quiet_ticks = '0;
    mismatches  = 0;
  endfunction

  // register write as the unit sees it
  function void set_register(logic [vrw_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [15:0] data);
    case (idx)
      vrw_pkg::REG_LINEAR_LIMIT:  linear_cap    = data[14:0];
      vrw_pkg::REG_ANGULAR_LIMIT: angular_cap   = data[14:0];
      vrw_pkg::REG_STEP_PER_TICK: ramp_step     = data[14:0];
      vrw_pkg::REG_TIMEOUT_TICKS: watchdog_span = data;
      default: ;
    endcase
  endfunction

  // symmetric clamp, limit capped at the largest 16-bit velocity
  function int clamp_axis(int v, int cap);
    if (cap > 32767) cap = 32767;
    if (v > cap) return cap;
    if (v < -cap) return -cap;
    return v;
  endfunction

  // move toward the goal by at most one step
  function int ramp_axis(int cur, int tgt, int stp);
    int d;
    d = tgt - cur;
    if (d > stp) return cur + stp;
    if (d < -stp) return cur - stp;
    return tgt;
  endfunction

  function int outstanding();
    return awaited_ramp.size();
  endfunction

  // accepted input beat: a command loads goals, a tick ramps and queues a result
  function void note_beat(vrw_pkg::command_t kind, logic signed [15:0] x,
                          logic signed [15:0] y, logic signed [15:0] z);
    vrw_pkg::result_t due;
    bit fired;
    if (kind == vrw_pkg::CMD_VELOCITY) begin
      goal[0] = clamp_axis(x, linear_cap);
      goal[1] = clamp_axis(y, linear_cap);
      goal[2] = clamp_axis(z, angular_cap);
      quiet_ticks = '0;
      return;
    end
    // watchdog count saturates at its top
    if (quiet_ticks != 16'hFFFF) quiet_ticks++;
    fired = (quiet_ticks > watchdog_span);
    if (fired) foreach (goal[i]) goal[i] = 0;
    foreach (speed[i]) speed[i] = ramp_axis(speed[i], goal[i], ramp_step);
    due.vx        = 16'(speed[0]);
    due.vy        = 16'(speed[1]);
    due.yaw       = 16'(speed[2]);
    due.timed_out = fired;
    awaited_ramp.push_back(due);
  endfunction

  function void compare_field(string label, logic signed [16:0] want, logic signed [16:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
      mismatches++;
    end
  endfunction

  // result beat against the oldest prediction
  function void check_result(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic to);
    vrw_pkg::result_t due;
    if (awaited_ramp.size() == 0) begin
      $display("%0t: result beat with nothing pending, expected none actual %0d %0d %0d %0b",
               $time, x, y, z, to);
      mismatches++;
      return;
    end
    due = awaited_ramp.pop_front();
    compare_field("vx_out", due.vx, x);
    compare_field("vy_out", due.vy, y);
    compare_field("yaw_out", due.yaw, z);
    compare_field("timed_out", {16'd0, due.timed_out}, {16'd0, to});
  endfunction
endclass

module tb;

  localparam int STUCK_LIMIT = 2000;
  localparam int LONG_HOLD   = 60;

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  logic                                command;
  logic signed [15:0]                  vx_cmd;
  logic signed [15:0]                  vy_cmd;
  logic signed [15:0]                  yaw_cmd;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [15:0]                  vx_out;
  logic signed [15:0]                  vy_out;
  logic signed [15:0]                  yaw_out;
  logic                                timed_out;
  logic                                cfg_we;
  logic [vrw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [vrw_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

  ramp_scoreboard board;
  int idle_pct;
  bit long_hold;
  int cur_lin;
  int cur_timeout;
  int stuck_cycles;

  velocity_ramp_with_watchdog_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .vx_cmd(vx_cmd), .vy_cmd(vy_cmd), .yaw_cmd(yaw_cmd),
    .out_valid(out_valid), .out_stall(out_stall),
    .vx_out(vx_out), .vy_out(vy_out), .yaw_out(yaw_out), .timed_out(timed_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall bursts, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold = 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // observe accepted beats on both sides, watchdog on lack of progress
  always @(posedge clk) begin : observe
    logic took_in;
    logic took_out;
    took_in  = !rst && in_valid && in_stall === 1'b0;
    took_out = !rst && out_valid === 1'b1 && !out_stall;
    if (took_in) board.note_beat(vrw_pkg::command_t'(command), vx_cmd, vy_cmd, yaw_cmd);
    if (took_out) board.check_result(vx_out, vy_out, yaw_out, timed_out);
    if (rst || took_in || took_out) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // one input beat, held until taken, with an optional gap before it
  task automatic send_beat(input vrw_pkg::command_t c, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2)
      repeat ($urandom_range(1, 14)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    @(negedge clk);
    in_valid <= 1'b1;
    command  <= c;
    vx_cmd   <= x;
    vy_cmd   <= y;
    yaw_cmd  <= z;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic send_tick();
    send_beat(vrw_pkg::CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // wait for every pending result, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [vrw_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    board.set_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // all four registers; unused top bit of the 15-bit ones is random
  task automatic apply_settings(input int lin, input int ang, input int stp, input int tmo);
    write_reg(vrw_pkg::REG_LINEAR_LIMIT, {1'($urandom), 15'(lin)});
    write_reg(vrw_pkg::REG_ANGULAR_LIMIT, {1'($urandom), 15'(ang)});
    write_reg(vrw_pkg::REG_STEP_PER_TICK, {1'($urandom), 15'(stp)});
    write_reg(vrw_pkg::REG_TIMEOUT_TICKS, 16'(tmo));
    cur_lin     = lin;
    cur_timeout = tmo;
  endtask

  // command field value: extremes, near the linear limit, or anything
  function automatic logic [15:0] pick_velocity();
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'(cur_lin) + 16'($urandom_range(0, 2)) - 16'd1;
      3: v = 16'd0 - 16'(cur_lin) + 16'($urandom_range(0, 2)) - 16'd1;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // mostly a command followed by a run of ticks, some lone beats of either kind
  task automatic run_random_phase(input int beats);
    int sent;
    int run_len;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(0, 9) < 8) begin
        send_beat(vrw_pkg::CMD_VELOCITY, pick_velocity(), pick_velocity(), pick_velocity());
        run_len = $urandom_range(1, (cur_timeout < 27) ? cur_timeout + 3 : 30);
        repeat (run_len) send_tick();
        sent += run_len + 1;
      end else begin
        if ($urandom_range(0, 1) != 0) send_tick();
        else send_beat(vrw_pkg::CMD_VELOCITY, pick_velocity(), pick_velocity(),
                       pick_velocity());
        sent++;
      end
    end
  endtask

  initial begin
    int lin;
    int ang;
    int stp;
    int tmo;
    board       = new();
    idle_pct    = 0;
    long_hold   = 1'b0;
    cur_lin     = 4096;
    cur_timeout = 250;
    stuck_cycles = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    command   = vrw_pkg::CMD_TICK;
    vx_cmd    = '0;
    vy_cmd    = '0;
    yaw_cmd   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings, clamping of field extremes
    send_beat(vrw_pkg::CMD_VELOCITY, 16'h7FFF, 16'h8000, 16'h0000);
    send_tick();
    send_tick();
    send_beat(vrw_pkg::CMD_VELOCITY, 16'hFFFF, 16'h0001, 16'h8000);
    send_tick();
    settle();
    // limits at the largest velocity, full step
    apply_settings(32767, 32767, 32767, 5);
    send_beat(vrw_pkg::CMD_VELOCITY, 16'h8000, 16'h7FFF, 16'h8000);
    send_tick();
    send_tick();
    send_beat(vrw_pkg::CMD_VELOCITY, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_tick();
    settle();
    // step of zero holds the current velocity
    apply_settings(1000, 200, 0, 3);
    send_beat(vrw_pkg::CMD_VELOCITY, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_tick();
    send_tick();
    settle();
    // zero limits and a zero timeout fire on the first tick
    apply_settings(0, 0, 100, 0);
    send_beat(vrw_pkg::CMD_VELOCITY, 16'h1234, 16'hEDCC, 16'h7FFF);
    send_tick();
    send_tick();
    settle();
    // watchdog fires once the count passes the timeout
    apply_settings(300, 300, 100, 2);
    send_beat(vrw_pkg::CMD_VELOCITY, 16'h7FFF, 16'h8000, 16'h7FFF);
    repeat (4) send_tick();
    send_beat(vrw_pkg::CMD_VELOCITY, 16'h0000, 16'h0000, 16'h0000);
    send_tick();

    // random phases over a spread of settings
    for (int p = 1; p <= 8; p++) begin
      settle();
      case (p)
        1: apply_settings(32767, 32767, 32767, 0);
        2: apply_settings(0, 0, 0, 65535);
        default: begin
          lin = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 8192);
          ang = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 8192);
          case ($urandom_range(0, 2))
            0: stp = $urandom_range(1, 32);
            1: stp = $urandom_range(1, 2048);
            default: stp = $urandom_range(0, 32767);
          endcase
          tmo = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
          apply_settings(lin, ang, stp, tmo);
        end
      endcase
      idle_pct = (p % 3 == 0 || p == 8) ? 0 : 20;
      // receiver holds off while ticks keep coming, so the unit backs up
      if (p == 4) begin
        idle_pct = 0;
        long_hold = 1'b1;
        repeat (40) send_tick();
        idle_pct = 20;
      end
      run_random_phase(65);
    end

    settle();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/vrw_pkg.sv
hdl/vrw_lane.sv
hdl/vrw_watchdog.sv
hdl/vrw_merge.sv
hdl/velocity_ramp_with_watchdog_unit.sv
hdl/vrw_checker.sv
tb/sv/tb.sv
